>>> design/psfe_pkg.sv
// Shared types and constants for the protobuf scalar field encoder.
// No dependencies.
`default_nettype none

package psfe_pkg;

   localparam int unsigned VALUE_WIDTH  = 64;
   localparam int unsigned OPCODE_WIDTH = 3;
   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned COUNT_WIDTH  = 3;

   localparam logic [6:0] VARINT_GROUP_MASK = 7'h7f;
   localparam logic [7:0] VARINT_CONT_BIT   = 8'h80;

   localparam logic [COUNT_WIDTH-1:0] FIXED32_LAST_IDX = 3'd3;
   localparam logic [COUNT_WIDTH-1:0] FIXED64_LAST_IDX = 3'd7;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_UINT32   = 3'd0,
      OP_UINT64   = 3'd1,
      OP_ZIGZAG32 = 3'd2,
      OP_ZIGZAG64 = 3'd3,
      OP_FIXED32  = 3'd4,
      OP_FIXED64  = 3'd5
   } op_type;

   typedef struct packed {
      logic load;   // capture a new item into the datapath
      logic shift;  // advance to the next wire byte
   } cmd_type;

   typedef struct packed {
      logic op_ok;  // opcode on the request channel is a defined encoding
      logic last;   // current wire byte is the final one
   } status_type;

endpackage

`default_nettype wire

>>> design/psfe_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on psfe_pkg.
`default_nettype none

interface psfe_req_if import psfe_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OPCODE_WIDTH-1:0] opcode;
   logic [VALUE_WIDTH-1:0]  value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface psfe_rsp_if import psfe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] out_byte;
   logic                  last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

>>> design/psfe_ctrl.sv
// Controller FSM: sequences load and per-byte shift of the datapath.
// Depends on psfe_pkg.
`default_nettype none

module psfe_ctrl import psfe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      finishing;
   logic      accept;

   // final byte leaves this cycle: a new item may load at once
   assign finishing = (state_ff == ST_EMIT) && rsp_ready && status.last;
   assign req_ready = (state_ff == ST_IDLE) || finishing;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.load  = accept && status.op_ok;
      cmd.shift = (state_ff == ST_EMIT) && rsp_ready && !status.last;
      state_in  = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (finishing) state_in = cmd.load ? ST_EMIT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

>>> design/psfe_datapath.sv
// Datapath: zigzag mapping, 64-bit shift word and fixed byte counter.
// Depends on psfe_pkg.
`default_nettype none

module psfe_datapath import psfe_pkg::*; (
   input  wire logic                    clock,
   input  wire logic [OPCODE_WIDTH-1:0] opcode,
   input  wire logic [VALUE_WIDTH-1:0]  value,
   input  wire cmd_type                 cmd,
   output status_type                   status,
   output logic [BYTE_WIDTH-1:0]        out_byte
);

   logic [VALUE_WIDTH-1:0] word_ff, word_in;
   logic                   fixed_ff, fixed_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [31:0]            lo;
   logic [31:0]            zz32;
   logic [VALUE_WIDTH-1:0] zz64;
   logic [VALUE_WIDTH-1:0] enc_word;
   logic                   enc_fixed;
   logic [COUNT_WIDTH-1:0] enc_count;
   logic                   op_ok;
   logic                   more;

   assign lo   = value[31:0];
   assign zz32 = {lo[30:0], 1'b0} ^ {32{lo[31]}};
   assign zz64 = {value[VALUE_WIDTH-2:0], 1'b0} ^ {VALUE_WIDTH{value[VALUE_WIDTH-1]}};

   always_comb begin
      enc_word  = value;
      enc_fixed = 1'b0;
      enc_count = '0;
      op_ok     = 1'b1;
      unique case (op_type'(opcode))
         OP_UINT32:   enc_word = {32'd0, lo};
         OP_UINT64:   enc_word = value;
         OP_ZIGZAG32: enc_word = {32'd0, zz32};
         OP_ZIGZAG64: enc_word = zz64;
         OP_FIXED32: begin
            enc_word  = {32'd0, lo};
            enc_fixed = 1'b1;
            enc_count = FIXED32_LAST_IDX;
         end
         OP_FIXED64: begin
            enc_fixed = 1'b1;
            enc_count = FIXED64_LAST_IDX;
         end
         default: op_ok = 1'b0;
      endcase
   end

   // varint continues while bits remain above the current 7-bit group
   assign more = |word_ff[VALUE_WIDTH-1:7];

   always_comb begin
      if (fixed_ff) begin
         out_byte    = word_ff[BYTE_WIDTH-1:0];
         status.last = (count_ff == '0);
      end else begin
         out_byte    = (more ? VARINT_CONT_BIT : 8'h00)
                     | {1'b0, word_ff[6:0] & VARINT_GROUP_MASK};
         status.last = !more;
      end
      status.op_ok = op_ok;
   end

   always_comb begin
      priority if (cmd.load) begin
         word_in  = enc_word;
         fixed_in = enc_fixed;
         count_in = enc_count;
      end else if (cmd.shift) begin
         word_in  = fixed_ff ? (word_ff >> 8) : (word_ff >> 7);
         fixed_in = fixed_ff;
         count_in = count_ff - 1'b1;
      end else begin
         word_in  = word_ff;
         fixed_in = fixed_ff;
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      fixed_ff <= fixed_in;
      count_ff <= count_in;
   end

endmodule

`default_nettype wire

>>> design/protobuf_scalar_field_encoder.sv
// Protobuf scalar field encoder: a value in, wire bytes out one per ready cycle.
// First byte: valid in the cycle after the item is accepted.
// Output: N bytes per item (1..5 / 1..10 varint, 4 or 8 fixed), one per
//   cycle while rsp_port.ready is high, set by the single shift word in the
//   datapath; the next item loads in the cycle its last byte is taken.
// Reset: synchronous, active high; returns the controller to idle.
`default_nettype none

module protobuf_scalar_field_encoder import psfe_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   psfe_req_if.sink   req_port,
   psfe_rsp_if.source rsp_port
);

   cmd_type    cmd;
   status_type status;

   // Controller: owns the handshake, decides load vs. shift per cycle.
   psfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: zigzag/select on load, then 7-bit (varint) or 8-bit (fixed)
   // shifts per emitted byte. Undefined opcodes are dropped with no output.
   psfe_datapath u_datapath (
      .clock    (clock),
      .opcode   (req_port.opcode),
      .value    (req_port.value),
      .cmd      (cmd),
      .status   (status),
      .out_byte (rsp_port.out_byte)
   );

   assign rsp_port.last = status.last;

endmodule

`default_nettype wire
